@@ design/shirr_pkg.sv @@
// shared constants, types and fixed-point helpers of the harmonic irradiance shader
`timescale 1ns / 1ps
`default_nettype none

package shirr_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int NUM_BASIS     = 25;

  localparam int NRM_W      = 16;
  localparam int COEF_W     = 24;
  localparam int IDX_W      = 5;
  localparam int CLR_W      = 8;
  localparam int IRR_W      = 32;
  localparam int SQ_W       = 18;
  localparam int MID_W      = 21;
  localparam int QM_W       = 24;
  localparam int TERM_W     = 25;
  localparam int PROD_W     = COEF_W + TERM_W;
  localparam int ACC_W      = PROD_W + 5;
  localparam int FRAC       = 14;
  localparam int ORD_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  typedef enum logic {
    OP_SHADE = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHADING_ENABLE = 1'b0,
    CFG_HARMONIC_ORDER = 1'b1
  } cfg_idx_e;

  typedef logic signed [TERM_W-1:0] term_t;

  // stage advance strobes for the basis pipeline
  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
  } basis_en_t;

  // q14 product, rounded to nearest with ties away from zero
  function automatic logic signed [QM_W-1:0] qmul(input logic signed [QM_W-1:0] a,
                                                  input logic signed [QM_W-1:0] b);
    logic signed [2*QM_W-1:0] p;
    logic signed [2*QM_W-1:0] half;
    logic signed [2*QM_W-1:0] r;
    p = a * b;
    half = '0;
    half[FRAC-1] = 1'b1;
    r = (p + half - $signed({{(2*QM_W-1){1'b0}}, p[2*QM_W-1]})) >>> FRAC;
    return r[QM_W-1:0];
  endfunction

  // harmonic band of a basis term
  function automatic logic [ORD_W-1:0] band_of(input int unsigned i);
    logic [ORD_W-1:0] b;
    b = '0;
    for (int k = 1; k <= MAX_ORDER_DEF; k++) begin
      if (i >= k * k) begin
        b = ORD_W'(k);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/shirr_basis.sv @@
// three-stage pipeline that evaluates the 25 spherical-harmonic basis terms at a normal
`timescale 1ns / 1ps
`default_nettype none

module shirr_basis (
  input  logic                                   clk_i,
  input  shirr_pkg::basis_en_t                   en_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]     normal_x_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]     normal_y_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]     normal_z_i,
  output shirr_pkg::term_t                       terms_o [shirr_pkg::NUM_BASIS]
);
  import shirr_pkg::*;

  localparam logic signed [MID_W-1:0]  K3    = MID_W'(3);
  localparam logic signed [MID_W-1:0]  K5    = MID_W'(5);
  localparam logic signed [MID_W-1:0]  K7    = MID_W'(7);
  localparam logic signed [MID_W-1:0]  One   = MID_W'(16384);
  localparam logic signed [MID_W-1:0]  Three = MID_W'(49152);
  localparam logic signed [TERM_W-1:0] K30T  = TERM_W'(30);
  localparam logic signed [TERM_W-1:0] K35T  = TERM_W'(35);

  // stage 0: normal and its quadratic products
  logic signed [NRM_W-1:0] x0_q, y0_q, z0_q;
  logic signed [SQ_W-1:0]  x2_0_d, y2_0_d, z2_0_d, xy0_d, xz0_d, yz0_d;
  logic signed [SQ_W-1:0]  x2_0_q, y2_0_q, z2_0_q, xy0_q, xz0_q, yz0_q;

  assign x2_0_d = SQ_W'(qmul(normal_x_i, normal_x_i));
  assign y2_0_d = SQ_W'(qmul(normal_y_i, normal_y_i));
  assign z2_0_d = SQ_W'(qmul(normal_z_i, normal_z_i));
  assign xy0_d  = SQ_W'(qmul(normal_x_i, normal_y_i));
  assign xz0_d  = SQ_W'(qmul(normal_x_i, normal_z_i));
  assign yz0_d  = SQ_W'(qmul(normal_y_i, normal_z_i));

  always_ff @(posedge clk_i) begin
    if (en_i.s0) begin
      x0_q   <= normal_x_i;
      y0_q   <= normal_y_i;
      z0_q   <= normal_z_i;
      x2_0_q <= x2_0_d;
      y2_0_q <= y2_0_d;
      z2_0_q <= z2_0_d;
      xy0_q  <= xy0_d;
      xz0_q  <= xz0_d;
      yz0_q  <= yz0_d;
    end
  end

  // stage 1: linear combinations of the squares, and z2 squared
  logic signed [NRM_W-1:0]  x1_q, y1_q, z1_q;
  logic signed [SQ_W-1:0]   x2_1_q, y2_1_q, xy1_q, xz1_q, yz1_q;
  logic signed [MID_W-1:0]  mx2, my2, mz2;
  logic signed [MID_W-1:0]  a_d, b_d, dd_d, z7a_d, z7b_d, f5a_d, f5b_d, t8_d, zz_d;
  logic signed [MID_W-1:0]  a_q, b_q, dd_q, z7a_q, z7b_q, f5a_q, f5b_q, t8_q, zz_q;
  logic signed [TERM_W-1:0] c20_d, c20_q;

  always_comb begin
    mx2   = MID_W'(x2_0_q);
    my2   = MID_W'(y2_0_q);
    mz2   = MID_W'(z2_0_q);
    a_d   = K3 * mx2 - my2;
    b_d   = mx2 - K3 * my2;
    dd_d  = mx2 - my2;
    z7a_d = K7 * mz2 - One;
    z7b_d = K7 * mz2 - Three;
    f5a_d = K5 * mz2 - One;
    f5b_d = K5 * mz2 - Three;
    t8_d  = K3 * mz2 - One;
    zz_d  = MID_W'(qmul(z2_0_q, z2_0_q));
    c20_d = TERM_W'(Three) - K30T * TERM_W'(z2_0_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      x1_q   <= x0_q;
      y1_q   <= y0_q;
      z1_q   <= z0_q;
      x2_1_q <= x2_0_q;
      y2_1_q <= y2_0_q;
      xy1_q  <= xy0_q;
      xz1_q  <= xz0_q;
      yz1_q  <= yz0_q;
      a_q    <= a_d;
      b_q    <= b_d;
      dd_q   <= dd_d;
      z7a_q  <= z7a_d;
      z7b_q  <= z7b_d;
      f5a_q  <= f5a_d;
      f5b_q  <= f5b_d;
      t8_q   <= t8_d;
      zz_q   <= zz_d;
      c20_q  <= c20_d;
    end
  end

  // stage 2: cubic and quartic terms
  term_t term_d [NUM_BASIS];
  term_t term_q [NUM_BASIS];

  always_comb begin
    term_d[0]  = TERM_W'(One);
    term_d[1]  = TERM_W'(x1_q);
    term_d[2]  = TERM_W'(y1_q);
    term_d[3]  = TERM_W'(z1_q);
    term_d[4]  = TERM_W'(xy1_q);
    term_d[5]  = TERM_W'(xz1_q);
    term_d[6]  = TERM_W'(yz1_q);
    term_d[7]  = TERM_W'(dd_q);
    term_d[8]  = TERM_W'(t8_q);
    term_d[9]  = TERM_W'(qmul(a_q, y1_q));
    term_d[10] = TERM_W'(qmul(xy1_q, z1_q));
    term_d[11] = TERM_W'(qmul(f5a_q, y1_q));
    term_d[12] = TERM_W'(qmul(f5b_q, z1_q));
    term_d[13] = TERM_W'(qmul(f5a_q, x1_q));
    term_d[14] = TERM_W'(qmul(dd_q, z1_q));
    term_d[15] = TERM_W'(qmul(b_q, x1_q));
    term_d[16] = TERM_W'(qmul(dd_q, xy1_q));
    term_d[17] = TERM_W'(qmul(a_q, yz1_q));
    term_d[18] = TERM_W'(qmul(z7a_q, xy1_q));
    term_d[19] = TERM_W'(qmul(z7b_q, yz1_q));
    term_d[20] = c20_q + K35T * TERM_W'(zz_q);
    term_d[21] = TERM_W'(qmul(z7b_q, xz1_q));
    term_d[22] = TERM_W'(qmul(z7a_q, dd_q));
    term_d[23] = TERM_W'(qmul(b_q, xz1_q));
    term_d[24] = TERM_W'(qmul(b_q, x2_1_q)) - TERM_W'(qmul(a_q, y2_1_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      for (int i = 0; i < NUM_BASIS; i++) begin
        term_q[i] <= term_d[i];
      end
    end
  end

  assign terms_o = term_q;

endmodule

`default_nettype wire

@@ design/sh_irradiance_vertex_shader_top.sv @@
// Harmonic irradiance vertex shader: an eight-stage pipeline that takes one transaction per
// cycle unless stalled by backpressure. Stages 0-2 evaluate the spherical-harmonic basis at
// the normal, stage 3 multiplies every term by its coefficient in parallel lanes, stages 4
// and 5 sum the lanes in a registered tree, and while shading is enabled stage 6 rounds and
// saturates the irradiance and stage 7 scales the colour into the output register. A load
// transaction travels the same pipeline and writes the coefficient table as it leaves
// stage 2, where shade transactions read it, so loads and shades take effect in stream
// order; loads produce no result. Backpressure stalls only the stages that are full, so
// bubbles close up. Configuration writes are taken in any cycle and must be made while the
// pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module sh_irradiance_vertex_shader_top #(
  parameter int MaxOrder = shirr_pkg::MAX_ORDER_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    op_i,
  input  logic        [shirr_pkg::IDX_W-1:0]      coeff_index_i,
  input  logic signed [shirr_pkg::COEF_W-1:0]     coeff_value_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]      normal_x_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]      normal_y_i,
  input  logic signed [shirr_pkg::NRM_W-1:0]      normal_z_i,
  input  logic        [shirr_pkg::CLR_W-1:0]      red_in_i,
  input  logic        [shirr_pkg::CLR_W-1:0]      green_in_i,
  input  logic        [shirr_pkg::CLR_W-1:0]      blue_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic        [shirr_pkg::CLR_W-1:0]      red_out_o,
  output logic        [shirr_pkg::CLR_W-1:0]      green_out_o,
  output logic        [shirr_pkg::CLR_W-1:0]      blue_out_o,
  output logic signed [shirr_pkg::IRR_W-1:0]      irradiance_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic        [shirr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [shirr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import shirr_pkg::*;

  localparam int NumTerms  = (MaxOrder + 1) * (MaxOrder + 1);
  localparam int GrpSize   = 5;
  localparam int NumGroups = (NumTerms + GrpSize - 1) / GrpSize;
  localparam int NumStg    = 8;
  localparam int StgTbl    = 3;
  localparam int PW        = CLR_W + IRR_W - 1;
  localparam int SclSh     = 16;
  localparam int VW        = PW - SclSh;

  localparam logic signed [ACC_W-1:0] IrrMax = {{(ACC_W-IRR_W+1){1'b0}}, {(IRR_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] IrrMin = {{(ACC_W-IRR_W+1){1'b1}}, {(IRR_W-1){1'b0}}};

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   idx;
    logic [COEF_W-1:0]  val;
    logic [CLR_W-1:0]   r;
    logic [CLR_W-1:0]   g;
    logic [CLR_W-1:0]   b;
  } side_t;

  // colour times irradiance, rounded half up, clamped to 0..255
  function automatic logic [CLR_W-1:0] scale(input logic [CLR_W-1:0] c,
                                             input logic signed [IRR_W-1:0] irr);
    logic [PW-1:0]    p;
    logic [PW-1:0]    half;
    logic [PW-1:0]    sum;
    logic [VW-1:0]    v;
    logic [CLR_W-1:0] res;
    half = '0;
    half[SclSh-1] = 1'b1;
    p = c * irr[IRR_W-2:0];
    sum = p + half;
    v = sum[PW-1:SclSh];
    if (irr[IRR_W-1]) begin
      res = '0;
    end else if (|v[VW-1:CLR_W]) begin
      res = '1;
    end else begin
      res = v[CLR_W-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic             shading_enable_q;
  logic [ORD_W-1:0] harmonic_order_q;
  logic [ORD_W-1:0] ord_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shading_enable_q <= 1'b0;
      harmonic_order_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SHADING_ENABLE: shading_enable_q <= cfg_data_i[0];
        CFG_HARMONIC_ORDER: harmonic_order_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ord_eff = (harmonic_order_q > ORD_W'(MaxOrder)) ? ORD_W'(MaxOrder) : harmonic_order_q;

  // pipeline control: a stage advances when it is empty or the next one advances
  logic [NumStg-1:0] v_d, v_q, en;
  side_t             side_d;
  side_t             side_q [NumStg-1];

  always_comb begin
    en[NumStg-1] = ~v_q[NumStg-1] | out_ready_i;
    for (int s = NumStg - 2; s >= 0; s--) begin
      en[s] = ~v_q[s] | en[s+1];
    end
  end

  assign in_ready_o = en[0];

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int s = 1; s < NumStg; s++) begin
      if (en[s]) begin
        v_d[s] = v_q[s-1];
      end
    end
    // loads end at the table
    if (en[StgTbl]) begin
      v_d[StgTbl] = v_q[StgTbl-1] & (side_q[StgTbl-1].op == OP_SHADE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign side_d = '{op: op_e'(op_i), idx: coeff_index_i, val: coeff_value_i,
                    r: red_in_i, g: green_in_i, b: blue_in_i};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
    end
    for (int s = 1; s < NumStg - 1; s++) begin
      if (en[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // stages 0-2: basis terms
  basis_en_t ben;
  term_t     terms [NUM_BASIS];

  assign ben = '{s0: en[0], s1: en[1], s2: en[2]};

  shirr_basis u_basis (
    .clk_i      (clk_i),
    .en_i       (ben),
    .normal_x_i (normal_x_i),
    .normal_y_i (normal_y_i),
    .normal_z_i (normal_z_i),
    .terms_o    (terms)
  );

  // coefficient table, written by a load as it leaves stage 2
  logic                     tbl_we;
  logic signed [COEF_W-1:0] coef_q [NumTerms];

  assign tbl_we = en[StgTbl] & v_q[StgTbl-1] & (side_q[StgTbl-1].op == OP_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumTerms; i++) begin
        coef_q[i] <= '0;
      end
    end else if (tbl_we) begin
      for (int i = 0; i < NumTerms; i++) begin
        if (side_q[StgTbl-1].idx == IDX_W'(i)) begin
          coef_q[i] <= $signed(side_q[StgTbl-1].val);
        end
      end
    end
  end

  // stage 3: per-lane products, lanes above the configured band read zero
  logic [NumTerms-1:0]      lane_on;
  logic signed [PROD_W-1:0] prod_d [NumTerms];
  logic signed [PROD_W-1:0] prod_q [NumTerms];

  always_comb begin
    for (int i = 0; i < NumTerms; i++) begin
      lane_on[i] = band_of(i) <= ord_eff;
      if (lane_on[i]) begin
        prod_d[i] = coef_q[i] * terms[i];
      end else begin
        prod_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int i = 0; i < NumTerms; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
  end

  // stage 4: group sums
  logic signed [ACC_W-1:0] grp_d [NumGroups];
  logic signed [ACC_W-1:0] grp_q [NumGroups];

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_d[g] = '0;
    end
    for (int i = 0; i < NumTerms; i++) begin
      grp_d[i / GrpSize] = grp_d[i / GrpSize] + ACC_W'(prod_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int g = 0; g < NumGroups; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  // stage 5: full dot product in q30
  logic signed [ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      acc_d = acc_d + grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      acc_q <= acc_d;
    end
  end

  // stage 6: round to q16.16 and saturate, or zero when shading is disabled
  logic signed [ACC_W-1:0] acc_half;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [IRR_W-1:0] irr_d, irr_q;

  always_comb begin
    acc_half = '0;
    acc_half[FRAC-1] = 1'b1;
    acc_rnd = (acc_q + acc_half - $signed({{(ACC_W-1){1'b0}}, acc_q[ACC_W-1]})) >>> FRAC;
    if (!shading_enable_q) begin
      irr_d = '0;
    end else if (acc_rnd > IrrMax) begin
      irr_d = IrrMax[IRR_W-1:0];
    end else if (acc_rnd < IrrMin) begin
      irr_d = IrrMin[IRR_W-1:0];
    end else begin
      irr_d = acc_rnd[IRR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      irr_q <= irr_d;
    end
  end

  // stage 7: colour scaling into the output register, bypassed when shading is disabled
  logic [CLR_W-1:0]        red_d, green_d, blue_d;
  logic [CLR_W-1:0]        red_q, green_q, blue_q;
  logic signed [IRR_W-1:0] irr_out_q;

  always_comb begin
    if (shading_enable_q) begin
      red_d   = scale(side_q[6].r, irr_q);
      green_d = scale(side_q[6].g, irr_q);
      blue_d  = scale(side_q[6].b, irr_q);
    end else begin
      red_d   = side_q[6].r;
      green_d = side_q[6].g;
      blue_d  = side_q[6].b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      irr_out_q <= irr_q;
    end
  end

  assign out_valid_o  = v_q[NumStg-1];
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign irradiance_o = irr_out_q;

endmodule

`default_nettype wire

@@ design/shirr_checker.sv @@
// port-level checks of the harmonic irradiance shader and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module shirr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic        [shirr_pkg::CLR_W-1:0]  red_out_o,
  input logic        [shirr_pkg::CLR_W-1:0]  green_out_o,
  input logic        [shirr_pkg::CLR_W-1:0]  blue_out_o,
  input logic signed [shirr_pkg::IRR_W-1:0]  irradiance_o
);
  import shirr_pkg::*;

  // a stalled result keeps its valid and its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) &&
      $stable(green_out_o) && $stable(blue_out_o) && $stable(irradiance_o))
    else $error("stalled result changed");

  // negative irradiance darkens every channel
  a_neg_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && irradiance_o[IRR_W-1] |->
      red_out_o == '0 && green_out_o == '0 && blue_out_o == '0)
    else $error("negative irradiance with lit colour");

  // an unstalled output lets the whole pipeline move
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  // an empty output stage never blocks the input
  a_empty_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind sh_irradiance_vertex_shader_top shirr_checker u_shirr_checker (.*);

`default_nettype wire
